// ----- sv/trie_pkg.sv -----
// shared types and operation codes for the trie word prefix store
`timescale 1ns / 1ps
`default_nettype none

package trie_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic step;
        logic finish;
    } trie_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_done;
        logic step_go;
        logic last_in;
        logic last_held;
        logic out_free;
    } trie_stat_t;

endpackage

`default_nettype wire

// ----- sv/trie_ctrl.sv -----
// controller state machine sequencing clear pass, letter steps and results
`timescale 1ns / 1ps
`default_nettype none

module trie_ctrl
    import trie_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire trie_stat_t stat,
    output trie_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_MARK,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (stat.step_go)
                    begin
                        state_next = ST_STEP;
                    end
                    else if (stat.last_in)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.last_held ? ST_MARK : ST_IDLE;
            end
            ST_MARK:
            begin
                // word mark read of the final node lands next cycle
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // a result is only committed when the output register can take it
    a_finish_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result committed into a busy output register");

    // no item is taken before the clear pass is over
    a_no_accept_clear : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !in_ready)
        else $error("item accepted during clear pass");

    // a step always follows an accepted item that needed one
    a_step_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.step_go) |=> cmd.step)
        else $error("letter step missing after accept");
`endif

endmodule

`default_nettype wire

// ----- sv/trie_dp.sv -----
// datapath: child link memory, word mark memory, cursor, allocator and result register
`timescale 1ns / 1ps
`default_nettype none

module trie_dp
    import trie_pkg::*;
#(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire trie_cmd_t  cmd,
    output trie_stat_t      stat,
    input  wire logic [1:0] operation,
    input  wire logic [4:0] letter,
    input  wire logic       first,
    input  wire logic       last,
    input  wire logic       is_empty,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            answer,
    output logic            pool_full
);

    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SLOT_W     = $clog2(LINK_DEPTH);
    localparam int FREE_W     = NODE_W + 1;

    logic [NODE_W-1:0] link_mem [LINK_DEPTH];
    logic              mark_mem [NODE_COUNT];

    logic [NODE_W-1:0] cursor_reg;
    logic              dead_reg;
    logic              full_reg;
    logic [FREE_W-1:0] free_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [1:0]        op_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic              answer_reg;
    logic              full_out_reg;
    logic [NODE_W-1:0] link_q;
    logic              mark_q;

    logic [NODE_W-1:0] cur_eff;
    logic              dead_eff;
    logic              full_eff;
    logic              need_step;
    logic              in_range;
    logic [SLOT_W-1:0] slot_next;
    logic              pool_out;
    logic              alloc;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata;
    logic              clr_mark;
    logic              set_mark;
    logic              res_answer;
    logic              res_full;

    // effect of first, then the walk decision for this letter
    assign cur_eff   = first ? '0 : cursor_reg;
    assign dead_eff  = first ? 1'b0 : dead_reg;
    assign full_eff  = first ? 1'b0 : full_reg;
    assign need_step = !is_empty && !dead_eff;
    assign in_range  = 32'(letter) < ALPHABET;
    assign slot_next = SLOT_W'(cur_eff) * SLOT_W'(ALPHABET) + SLOT_W'(letter);

    assign pool_out = free_reg >= FREE_W'(NODE_COUNT);
    assign alloc    = cmd.step && (link_q == '0) && (op_reg == OP_INSERT) && !pool_out;

    assign link_we    = cmd.clear || alloc;
    assign link_waddr = cmd.clear ? clr_reg : slot_reg;
    assign link_wdata = cmd.clear ? '0 : free_reg[NODE_W-1:0];

    assign clr_mark = cmd.clear && (32'(clr_reg) < NODE_COUNT);
    assign set_mark = cmd.finish && (op_reg == OP_INSERT) && !dead_reg;

    always_comb
    begin
        res_answer = 1'b0;
        res_full   = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                res_answer = !dead_reg;
                res_full   = dead_reg && full_reg;
            end
            OP_SEARCH:
            begin
                res_answer = !dead_reg && mark_q;
            end
            default:
            begin
                res_answer = !dead_reg;
            end
        endcase
    end

    // child link memory, registered read at the slot of the incoming letter
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[slot_next];
    end

    // word mark memory, read continuously at the cursor
    always_ff @(posedge clk)
    begin
        if (clr_mark)
        begin
            mark_mem[clr_reg[NODE_W-1:0]] <= 1'b0;
        end
        else if (set_mark)
        begin
            mark_mem[cursor_reg] <= 1'b1;
        end
        mark_q <= mark_mem[cursor_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg <= slot_next;
            op_reg   <= operation;
        end
        if (cmd.finish)
        begin
            answer_reg   <= res_answer;
            full_out_reg <= res_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            dead_reg      <= 1'b0;
            full_reg      <= 1'b0;
            free_reg      <= FREE_W'(1);
            clr_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                cursor_reg <= cur_eff;
                dead_reg   <= dead_eff || (need_step && !in_range);
                full_reg   <= full_eff;
                last_reg   <= last;
            end
            else if (cmd.step)
            begin
                if (link_q != '0)
                begin
                    cursor_reg <= link_q;
                end
                else if (op_reg != OP_INSERT)
                begin
                    dead_reg <= 1'b1;
                end
                else if (pool_out)
                begin
                    dead_reg <= 1'b1;
                    full_reg <= 1'b1;
                end
                else
                begin
                    cursor_reg <= free_reg[NODE_W-1:0];
                    free_reg   <= free_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_done = clr_reg == SLOT_W'(LINK_DEPTH - 1);
    assign stat.step_go    = need_step && in_range;
    assign stat.last_in    = last;
    assign stat.last_held  = last_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign pool_full = full_out_reg;

`ifndef SYNTH
    // the allocator never passes the pool size
    a_free_bound : assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(NODE_COUNT))
        else $error("allocator ran past the node pool");

    // the cursor only ever sits on an allocated node
    a_cursor_alloc : assert property (@(posedge clk) disable iff (!rst_n)
        FREE_W'(cursor_reg) < free_reg)
        else $error("cursor on an unallocated node");

    // a full pool result never reports success
    a_full_no_answer : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(answer_reg && full_out_reg))
        else $error("pool full reported together with success");
`endif

endmodule

`default_nettype wire

// ----- sv/trie_word_prefix_store.sv -----
// top level of the trie word prefix store: stream ports, controller and datapath
//
// a 26-letter prefix tree in a pool of NODE_COUNT nodes, root at node zero
// input channel s_*: one letter per item, operation and empty flag in tuser,
// letter and first-of-word flag in tdata, end of word on tlast
// output channel m_*: one result item for each input item that carries tlast
// operations: insert (allocates missing nodes in order, marks the word end),
// exact search, prefix test; an insert that needs a node with the pool used up
// is abandoned and reports pool_full
// sequencing: one item at a time; a letter that walks a child link is taken in
// ST_IDLE (accept issues the child memory read), then ST_STEP follows or allocates,
// an item with no step and no tlast takes ST_IDLE alone, and an item with tlast
// adds ST_MARK for the word mark memory read and ST_RESULT for the result commit
// ST_RESULT holds the result until the output register is free, then m_tvalid rises
// reset: after rst_n rises a clearing pass writes every child link and word
// mark to zero over all NODE_COUNT*ALPHABET slots (26624 by default); s_tready is
// low during the pass
// stall: a result waits in the output register while m_tready is low; the
// next item is still taken and walked, and only its own result waits
`timescale 1ns / 1ps
`default_nettype none

module trie_word_prefix_store
    import trie_pkg::*;
#(
    parameter int NODE_COUNT = 1024,
    parameter int ALPHABET   = 26
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] letter, [5] first, [7:6] zero
    input  wire logic [2:0] s_tuser,   // [1:0] operation, [2] is_empty
    input  wire logic       s_tlast,   // last letter of the word
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] answer, [1] pool_full, [7:2] zero
);

    trie_cmd_t  cmd;
    trie_stat_t stat;
    logic       answer;
    logic       pool_full;

    trie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    trie_dp #(
        .NODE_COUNT (NODE_COUNT),
        .ALPHABET   (ALPHABET)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (s_tuser[1:0]),
        .letter    (s_tdata[4:0]),
        .first     (s_tdata[5]),
        .last      (s_tlast),
        .is_empty  (s_tuser[2]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .answer    (answer),
        .pool_full (pool_full)
    );

    // result fields packed from bit zero, upper bits zero
    assign m_tdata = {6'b0, pool_full, answer};

endmodule

`default_nettype wire
